### hdl/kbd_pkg.sv
// Shared types, register indexes and character tables for the keyboard
// scancode translator. No dependencies; used by every module under hdl/.
package kbd_pkg;

  // Scancodes at or above this index have no table entry
  localparam int TABLE_ENTRIES = 115;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CAPS_LOCK   = 2'd0,
    CFG_LEFT_SHIFT  = 2'd1,
    CFG_RIGHT_SHIFT = 2'd2,
    CFG_MOUSE_THR   = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [6:0] CAPS_LOCK_RESET   = 7'd58;
  localparam logic [6:0] LEFT_SHIFT_RESET  = 7'd42;
  localparam logic [6:0] RIGHT_SHIFT_RESET = 7'd54;
  localparam logic [7:0] MOUSE_THR_RESET   = 8'hF8;

  // Configuration register contents
  typedef struct packed {
    logic [6:0] caps_lock_make_code;
    logic [6:0] left_shift_key;
    logic [6:0] right_shift_key;
    logic [7:0] mouse_header_threshold;
  } cfg_t;

  // Modifier state
  typedef enum logic [1:0] {
    MOD_NONE   = 2'd0,
    MOD_CAPS   = 2'd1,
    MOD_LSHIFT = 2'd2,
    MOD_RSHIFT = 2'd3
  } modifier_t;

  // Mouse packet skip phase
  typedef enum logic [1:0] {
    SKIP_IDLE   = 2'd0,
    SKIP_SECOND = 2'd1,
    SKIP_THIRD  = 2'd2,
    SKIP_SPARE  = 2'd3
  } skip_t;

  // Result of translating one item
  typedef struct packed {
    logic       emit;
    logic [6:0] ascii_char;
  } xlate_res_t;

  localparam logic [6:0] TAB_PLAIN [128] = '{
    7'h00,7'h1b,7'h31,7'h32,7'h33,7'h34,7'h35,7'h36,7'h37,7'h38,7'h39,7'h30,
    7'h2d,7'h3d,7'h08,7'h09,7'h71,7'h77,7'h65,7'h72,7'h74,7'h79,7'h75,7'h69,
    7'h6f,7'h70,7'h5b,7'h5d,7'h0d,7'h00,7'h61,7'h73,7'h64,7'h66,7'h67,7'h68,
    7'h6a,7'h6b,7'h6c,7'h3b,7'h27,7'h60,7'h00,7'h5c,7'h7a,7'h78,7'h63,7'h76,
    7'h62,7'h6e,7'h6d,7'h2c,7'h2e,7'h2f,7'h00,7'h00,7'h00,7'h20,7'h00,7'h00,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,
    7'h00,7'h00,7'h2d,7'h00,7'h00,7'h00,7'h2b,7'h00,7'h00,7'h00,7'h00,7'h7f,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,
    7'h00,7'h00,7'h00,7'h28,7'h29,7'h2f,7'h2a,7'h37,7'h38,7'h39,7'h34,7'h35,
    7'h36,7'h31,7'h32,7'h33,7'h30,7'h2e,7'h0d,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,
    7'h00
  };

  localparam logic [6:0] TAB_CAPS [128] = '{
    7'h00,7'h1b,7'h31,7'h32,7'h33,7'h34,7'h35,7'h36,7'h37,7'h38,7'h39,7'h30,
    7'h2d,7'h3d,7'h08,7'h09,7'h51,7'h57,7'h45,7'h52,7'h54,7'h59,7'h55,7'h49,
    7'h4f,7'h50,7'h5b,7'h5d,7'h0d,7'h00,7'h41,7'h53,7'h44,7'h46,7'h47,7'h48,
    7'h4a,7'h4b,7'h4c,7'h3b,7'h27,7'h60,7'h00,7'h5c,7'h5a,7'h58,7'h43,7'h56,
    7'h42,7'h4e,7'h4d,7'h2c,7'h2e,7'h2f,7'h00,7'h00,7'h00,7'h20,7'h00,7'h00,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,
    7'h00,7'h00,7'h2d,7'h00,7'h00,7'h00,7'h2b,7'h00,7'h00,7'h00,7'h00,7'h7f,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,
    7'h00,7'h00,7'h00,7'h28,7'h29,7'h2f,7'h2a,7'h37,7'h38,7'h39,7'h34,7'h35,
    7'h36,7'h31,7'h32,7'h33,7'h30,7'h2e,7'h0d,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,
    7'h00
  };

  localparam logic [6:0] TAB_SHIFT [128] = '{
    7'h00,7'h1b,7'h21,7'h40,7'h23,7'h24,7'h25,7'h5e,7'h26,7'h2a,7'h28,7'h29,
    7'h5f,7'h2b,7'h08,7'h09,7'h51,7'h57,7'h45,7'h52,7'h54,7'h59,7'h55,7'h49,
    7'h4f,7'h50,7'h7b,7'h7d,7'h0d,7'h00,7'h41,7'h53,7'h44,7'h46,7'h47,7'h48,
    7'h4a,7'h4b,7'h4c,7'h3a,7'h22,7'h7e,7'h00,7'h7c,7'h5a,7'h58,7'h43,7'h56,
    7'h42,7'h4e,7'h4d,7'h3c,7'h3e,7'h3f,7'h00,7'h00,7'h00,7'h20,7'h00,7'h00,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h37,
    7'h38,7'h00,7'h2d,7'h34,7'h00,7'h36,7'h2b,7'h00,7'h32,7'h00,7'h30,7'h7f,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,
    7'h00,7'h00,7'h00,7'h28,7'h29,7'h2f,7'h2a,7'h37,7'h38,7'h39,7'h34,7'h35,
    7'h36,7'h31,7'h32,7'h33,7'h30,7'h2e,7'h0d,
    7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,7'h00,
    7'h00
  };

  // Table lookup by modifier; both shift modes share the shifted table
  function automatic logic [6:0] table_lookup(modifier_t mode, logic [6:0] idx);
    logic [6:0] ch;
    unique case (mode)
      MOD_NONE:               ch = TAB_PLAIN[idx];
      MOD_CAPS:               ch = TAB_CAPS[idx];
      MOD_LSHIFT, MOD_RSHIFT: ch = TAB_SHIFT[idx];
      default:                ch = TAB_PLAIN[idx];
    endcase
    return ch;
  endfunction

endpackage

### hdl/kbd_cfg_regs.sv
// Configuration register file for the keyboard scancode translator.
// Depends on kbd_pkg (cfg_t, register indexes, reset values).
module kbd_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output kbd_pkg::cfg_t       cfg
);

  kbd_pkg::cfg_t regs;

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.caps_lock_make_code    <= kbd_pkg::CAPS_LOCK_RESET;
      regs.left_shift_key         <= kbd_pkg::LEFT_SHIFT_RESET;
      regs.right_shift_key        <= kbd_pkg::RIGHT_SHIFT_RESET;
      regs.mouse_header_threshold <= kbd_pkg::MOUSE_THR_RESET;
    end else if (cfg_wr_en) begin
      unique case (kbd_pkg::cfg_reg_t'(cfg_index))
        kbd_pkg::CFG_CAPS_LOCK:   regs.caps_lock_make_code    <= cfg_data[6:0];
        kbd_pkg::CFG_LEFT_SHIFT:  regs.left_shift_key         <= cfg_data[6:0];
        kbd_pkg::CFG_RIGHT_SHIFT: regs.right_shift_key        <= cfg_data[6:0];
        kbd_pkg::CFG_MOUSE_THR:   regs.mouse_header_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### hdl/kbd_xlate.sv
// Translation stage: mouse packet skipping, release filtering, modifier
// tracking and table lookup. Depends on kbd_pkg (types, tables).
module kbd_xlate #(
  parameter int TABLE_ENTRIES = kbd_pkg::TABLE_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  kbd_pkg::cfg_t           cfg,
  input  logic                    step,
  input  logic [7:0]              scan_byte,
  output kbd_pkg::xlate_res_t     res
);

  kbd_pkg::skip_t     skip_phase, skip_phase_next;
  kbd_pkg::modifier_t mode, mode_next;

  logic [7:0] caps_code, lshift_code, rshift_code, lrel_code, rrel_code;
  logic [6:0] table_char;
  logic       in_table;
  logic       lookup;

  assign caps_code   = {1'b0, cfg.caps_lock_make_code};
  assign lshift_code = {1'b0, cfg.left_shift_key};
  assign rshift_code = {1'b0, cfg.right_shift_key};
  assign lrel_code   = {1'b1, cfg.left_shift_key};
  assign rrel_code   = {1'b1, cfg.right_shift_key};

  assign in_table   = scan_byte < 8'(TABLE_ENTRIES);
  assign table_char = kbd_pkg::table_lookup(mode, scan_byte[6:0]);

  // Next state and lookup decision
  always_comb begin
    skip_phase_next = skip_phase;
    mode_next       = mode;
    lookup          = 1'b0;
    if (skip_phase == kbd_pkg::SKIP_SECOND) begin
      skip_phase_next = kbd_pkg::SKIP_THIRD;
    end else if (skip_phase != kbd_pkg::SKIP_IDLE) begin
      skip_phase_next = kbd_pkg::SKIP_IDLE;
    end else if (scan_byte >= cfg.mouse_header_threshold) begin
      skip_phase_next = kbd_pkg::SKIP_SECOND;
    end else if (scan_byte[7] && scan_byte != lrel_code && scan_byte != rrel_code) begin
      // release of a non-shift key: dropped
      lookup = 1'b0;
    end else begin
      unique case (mode)
        kbd_pkg::MOD_NONE: begin
          priority if (scan_byte == caps_code)   mode_next = kbd_pkg::MOD_CAPS;
          else if (scan_byte == lshift_code)     mode_next = kbd_pkg::MOD_LSHIFT;
          else if (scan_byte == rshift_code)     mode_next = kbd_pkg::MOD_RSHIFT;
          else                                   lookup    = 1'b1;
        end
        kbd_pkg::MOD_CAPS: begin
          if (scan_byte == caps_code) mode_next = kbd_pkg::MOD_NONE;
          else                        lookup    = 1'b1;
        end
        default: begin
          // shift held: its own release ends it, caps lock overrides
          priority if ((mode == kbd_pkg::MOD_LSHIFT && scan_byte == lrel_code) ||
                       (mode == kbd_pkg::MOD_RSHIFT && scan_byte == rrel_code))
            mode_next = kbd_pkg::MOD_NONE;
          else if (scan_byte == caps_code) mode_next = kbd_pkg::MOD_CAPS;
          else                             lookup    = 1'b1;
        end
      endcase
    end
  end

  // Result: only in-range, nonzero entries produce a character
  assign res.emit       = lookup && in_table && (table_char != 7'd0);
  assign res.ascii_char = table_char;

  // State registers advance once per consumed item
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_phase <= kbd_pkg::SKIP_IDLE;
      mode       <= kbd_pkg::MOD_NONE;
    end else if (step) begin
      skip_phase <= skip_phase_next;
      mode       <= mode_next;
    end
  end

endmodule

### hdl/keyboard_scancode_to_ascii.sv
// Keyboard scancode to ASCII translator. Raw controller bytes enter on
// in_valid/in_stall/scan_byte, one item per cycle sustained unless out_stall
// holds a waiting character; each byte is registered, translated in one pass
// through the mode logic and character table, and any resulting character
// lands in the output register. Bytes that give no character (mouse packets,
// releases, modifier keys, empty table slots) produce no output item. The
// input register moves on whenever the output register is empty or being
// taken, so out_stall holds back input only while a character waits.
// Configuration writes (caps lock, shift codes, mouse threshold) are taken
// with cfg_wr_en high; the user must make them only while idle (not enforced).
module keyboard_scancode_to_ascii #(
  parameter int TABLE_ENTRIES = kbd_pkg::TABLE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] ascii_char
);

  kbd_pkg::cfg_t      cfg;
  kbd_pkg::xlate_res_t res;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       result_valid;
  logic [6:0] result_char;
  logic       advance;
  logic       in_take;

  kbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: held item moves on when the output register has room
  assign advance  = !result_valid || !out_stall;
  assign in_stall = held_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  kbd_xlate #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_xlate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (held_valid && advance),
    .scan_byte (held_byte),
    .res       (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_byte <= scan_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid && res.emit) begin
      result_char <= res.ascii_char;
    end
  end

  assign out_valid  = result_valid;
  assign ascii_char = result_char;

endmodule

### verif/tb_top.sv
// Self-checking bench for the keyboard scancode translator: drives raw bytes
// under several key settings and compares every character with a predictor.
// Depends on hdl/kbd_pkg.sv (types, register indexes) and the translator RTL.
`timescale 1ns / 100ps

module tb_top;

  // Scancodes used by the directed part
  localparam logic [7:0] KEY_NONE      = 8'h00;
  localparam logic [7:0] KEY_ESC       = 8'h01;
  localparam logic [7:0] KEY_1         = 8'h02;
  localparam logic [7:0] KEY_Q         = 8'h10;
  localparam logic [7:0] KEY_EMPTY     = 8'h1d;
  localparam logic [7:0] KEY_A         = 8'h1e;
  localparam logic [7:0] KEY_PAD7      = 8'h47;
  localparam logic [7:0] KEY_PAD_ENTER = 8'h72;
  localparam logic [7:0] KEY_TOP       = 8'h7f;
  localparam logic [7:0] RELEASE_BIT   = 8'h80;

  // Character map selectors
  localparam int MAP_PLAIN = 0;
  localparam int MAP_CAPS  = 1;
  localparam int MAP_SHIFT = 2;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = kbd_pkg::CFG_CAPS_LOCK;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] scan_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [6:0] ascii_char;

  // Predictor state
  logic [6:0]         keymap [3][128];
  kbd_pkg::cfg_t      key_cfg;
  kbd_pkg::skip_t     skip_st;
  kbd_pkg::modifier_t mode_st;
  logic [6:0]         char_queue [$];
  logic [6:0]         want;

  int errors = 0;
  int items_sent = 0;
  int chars_checked = 0;
  int key_settings = 0;
  int input_held = 0;
  int burst_left = 0;
  int holds_req = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycle_no = 0;
  rx_pattern_t rx_mode = RX_FREE;

  keyboard_scancode_to_ascii uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .scan_byte  (scan_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ascii_char (ascii_char)
  );

  always #10 clk = ~clk;

  // Load one stretch of a character map; octal 001 marks an empty slot
  function automatic void fill_keys(int map, int first, string s);
    byte c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      keymap[map][first + i] = (c == 8'h01) ? 7'd0 : c[6:0];
    end
  endfunction

  function automatic void build_keymaps();
    byte c;
    for (int m = 0; m < 3; m++)
      for (int i = 0; i < 128; i++)
        keymap[m][i] = 7'd0;
    fill_keys(MAP_PLAIN, 0,
      "\001\0331234567890-=\010\tqwertyuiop[]\015\001asdfghjkl;'\140\001\\zxcvbnm,./\001\001\001 ");
    fill_keys(MAP_PLAIN, 72, "\001\001-\001\001\001+\001\001\001\001\177");
    fill_keys(MAP_PLAIN, 99, "()/*7894561230.\015");
    // caps lock only lifts the letters
    for (int i = 0; i < 128; i++) begin
      c = {1'b0, keymap[MAP_PLAIN][i]};
      keymap[MAP_CAPS][i] = (c >= "a" && c <= "z") ? c[6:0] - 7'd32 : c[6:0];
    end
    fill_keys(MAP_SHIFT, 0,
      "\001\033!@#$%^&*()_+\010\tQWERTYUIOP{}\015\001ASDFGHJKL:\"~\001|ZXCVBNM<>?\001\001\001 ");
    fill_keys(MAP_SHIFT, 71, "78\001-4\0016+\0012\0010\177");
    fill_keys(MAP_SHIFT, 99, "()/*7894561230.\015");
  endfunction

  // Next state and character for one accepted byte
  function automatic void translate_byte(input logic [7:0] b, output bit hit,
                                         output logic [6:0] ch);
    logic [7:0] caps_key, lshift_key, rshift_key, lshift_rel, rshift_rel;
    int sel;
    caps_key   = {1'b0, key_cfg.caps_lock_make_code};
    lshift_key = {1'b0, key_cfg.left_shift_key};
    rshift_key = {1'b0, key_cfg.right_shift_key};
    lshift_rel = lshift_key | RELEASE_BIT;
    rshift_rel = rshift_key | RELEASE_BIT;
    hit = 1'b0;
    ch  = 7'd0;
    sel = MAP_PLAIN;
    // rest of a mouse packet; the spare phase cannot be reached from outside
    if (skip_st == kbd_pkg::SKIP_SECOND) begin
      skip_st = kbd_pkg::SKIP_THIRD;
      return;
    end
    if (skip_st != kbd_pkg::SKIP_IDLE) begin
      skip_st = kbd_pkg::SKIP_IDLE;
      return;
    end
    if (b >= key_cfg.mouse_header_threshold) begin
      skip_st = kbd_pkg::SKIP_SECOND;
      return;
    end
    // only shift releases get past the break filter
    if (b[7] && b != lshift_rel && b != rshift_rel)
      return;
    case (mode_st)
      kbd_pkg::MOD_NONE: begin
        if (b == caps_key) begin
          mode_st = kbd_pkg::MOD_CAPS;
          return;
        end
        if (b == lshift_key) begin
          mode_st = kbd_pkg::MOD_LSHIFT;
          return;
        end
        if (b == rshift_key) begin
          mode_st = kbd_pkg::MOD_RSHIFT;
          return;
        end
        sel = MAP_PLAIN;
      end
      kbd_pkg::MOD_CAPS: begin
        if (b == caps_key) begin
          mode_st = kbd_pkg::MOD_NONE;
          return;
        end
        sel = MAP_CAPS;
      end
      default: begin
        if ((mode_st == kbd_pkg::MOD_LSHIFT && b == lshift_rel) ||
            (mode_st == kbd_pkg::MOD_RSHIFT && b == rshift_rel)) begin
          mode_st = kbd_pkg::MOD_NONE;
          return;
        end
        if (b == caps_key) begin
          mode_st = kbd_pkg::MOD_CAPS;
          return;
        end
        sel = MAP_SHIFT;
      end
    endcase
    // releases and codes past the map give nothing
    if (b < kbd_pkg::TABLE_ENTRIES) begin
      ch  = keymap[sel][b[6:0]];
      hit = (ch != 7'd0);
    end
  endfunction

  // Offer one byte and wait for it to be taken
  task automatic send_scan(input logic [7:0] b);
    bit         hit;
    logic [6:0] ch;
    in_valid  <= 1'b1;
    scan_byte <= b;
    do @(posedge clk); while (in_stall);
    translate_byte(b, hit, ch);
    if (hit)
      char_queue.push_back(ch);
    items_sent++;
  endtask

  // Send with bursty idling
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    send_scan(b);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait until every character is out and nothing is left in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (char_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input kbd_pkg::cfg_reg_t idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      kbd_pkg::CFG_CAPS_LOCK:   key_cfg.caps_lock_make_code    = val[6:0];
      kbd_pkg::CFG_LEFT_SHIFT:  key_cfg.left_shift_key         = val[6:0];
      kbd_pkg::CFG_RIGHT_SHIFT: key_cfg.right_shift_key        = val[6:0];
      default:                  key_cfg.mouse_header_threshold = val;
    endcase
  endtask

  // Program all four registers; the spare top bit of 7-bit codes is random
  task automatic apply_keys(input logic [6:0] caps, input logic [6:0] lshift,
                            input logic [6:0] rshift, input logic [7:0] thr);
    logic junk;
    settle();
    junk = 1'($urandom_range(0, 1));
    write_reg(kbd_pkg::CFG_CAPS_LOCK, {junk, caps});
    junk = 1'($urandom_range(0, 1));
    write_reg(kbd_pkg::CFG_LEFT_SHIFT, {junk, lshift});
    junk = 1'($urandom_range(0, 1));
    write_reg(kbd_pkg::CFG_RIGHT_SHIFT, {junk, rshift});
    write_reg(kbd_pkg::CFG_MOUSE_THR, thr);
    cfg_wr_en <= 1'b0;
    key_settings++;
  endtask

  // Reset settings: map edges, modifiers, releases, mouse packets
  task automatic test_reset_defaults();
    logic [7:0] seq [$];
    seq = '{KEY_ESC, KEY_NONE, KEY_A, KEY_PAD_ENTER, 8'(kbd_pkg::TABLE_ENTRIES),
            KEY_TOP, KEY_A | RELEASE_BIT, {1'b0, kbd_pkg::CAPS_LOCK_RESET}, KEY_Q,
            KEY_1, {1'b0, kbd_pkg::CAPS_LOCK_RESET},
            {1'b0, kbd_pkg::LEFT_SHIFT_RESET}, KEY_1, KEY_A,
            {1'b0, kbd_pkg::CAPS_LOCK_RESET}, KEY_A, {1'b1, kbd_pkg::LEFT_SHIFT_RESET},
            {1'b0, kbd_pkg::CAPS_LOCK_RESET}, {1'b0, kbd_pkg::RIGHT_SHIFT_RESET},
            KEY_PAD7, {1'b1, kbd_pkg::RIGHT_SHIFT_RESET},
            {1'b1, kbd_pkg::LEFT_SHIFT_RESET}, KEY_EMPTY,
            kbd_pkg::MOUSE_THR_RESET, KEY_A, KEY_A, 8'hff, KEY_1, 8'hff,
            kbd_pkg::MOUSE_THR_RESET - 8'd1, KEY_A};
    foreach (seq[i])
      offer_byte(seq[i]);
  endtask

  // Mostly typing sequences, some mouse packets and noise
  task automatic test_random_typing(input int n);
    int         start, r;
    logic [7:0] pick, lrel, rrel;
    start = items_sent;
    while (items_sent - start < n) begin
      r    = $urandom_range(0, 99);
      lrel = {1'b1, key_cfg.left_shift_key};
      rrel = {1'b1, key_cfg.right_shift_key};
      if (r < 50) begin
        pick = 8'($urandom_range(0, kbd_pkg::TABLE_ENTRIES - 1));
        offer_byte(pick);
      end else if (r < 58) begin
        pick = $urandom_range(0, 1) ? {1'b0, key_cfg.left_shift_key}
                                    : {1'b0, key_cfg.right_shift_key};
        offer_byte(pick);
      end else if (r < 66) begin
        if (mode_st == kbd_pkg::MOD_LSHIFT)
          pick = lrel;
        else if (mode_st == kbd_pkg::MOD_RSHIFT)
          pick = rrel;
        else
          pick = $urandom_range(0, 1) ? lrel : rrel;
        offer_byte(pick);
      end else if (r < 70) begin
        offer_byte({1'b0, key_cfg.caps_lock_make_code});
      end else if (r < 78) begin
        pick = 8'($urandom_range(0, 127));
        offer_byte(pick | RELEASE_BIT);
      end else if (r < 86) begin
        pick = 8'($urandom_range(255, key_cfg.mouse_header_threshold));
        offer_byte(pick);
        pick = 8'($urandom_range(0, 255));
        offer_byte(pick);
        pick = 8'($urandom_range(0, 255));
        offer_byte(pick);
      end else begin
        pick = 8'($urandom_range(0, 255));
        offer_byte(pick);
      end
    end
  endtask

  // Equal key codes and threshold extremes
  task automatic test_key_corners();
    logic [7:0] seq [$];
    apply_keys(KEY_A[6:0], KEY_A[6:0], KEY_A[6:0], 8'hff);
    seq = '{KEY_A, KEY_Q, KEY_A, KEY_Q, KEY_A | RELEASE_BIT, 8'hfe, 8'hff,
            KEY_A, KEY_A, KEY_Q};
    foreach (seq[i])
      offer_byte(seq[i]);
    // threshold zero: every byte belongs to a mouse packet
    apply_keys(7'd127, 7'd0, 7'd127, 8'h00);
    test_random_typing(30);
  endtask

  task automatic test_random_configs();
    apply_keys(7'h1d, 7'h2a, 7'h36, 8'he0);
    test_random_typing(180);
    apply_keys(7'd0, 7'd127, 7'd1, 8'hff);
    test_random_typing(180);
    apply_keys(7'h3a, 7'h36, 7'h36, 8'hc0);
    test_random_typing(180);
    apply_keys(7'h2a, 7'h10, 7'h1e, 8'h80);
    test_random_typing(180);
    repeat (2) begin
      apply_keys(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
      test_random_typing(180);
    end
    apply_keys(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127)), 8'h40);
    test_random_typing(150);
  endtask

  // Long receiver hold-off while letters keep coming
  task automatic test_output_hold();
    logic [7:0] pick;
    apply_keys(kbd_pkg::CAPS_LOCK_RESET, kbd_pkg::LEFT_SHIFT_RESET,
               kbd_pkg::RIGHT_SHIFT_RESET, kbd_pkg::MOUSE_THR_RESET);
    holds_req++;
    repeat (80) begin
      pick = 8'($urandom_range(KEY_Q, KEY_Q + 8'd9));
      offer_byte(pick);
    end
    test_random_typing(150);
  endtask

  // Receiver stall pattern, re-chosen at random while no hold-off runs
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_req) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      if (cycle_no % 50 == 0)
        rx_mode <= rx_pattern_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:  out_stall <= (cycle_no % 4 == 0);
      endcase
    end
  end

  // Compare each character taken with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (char_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual %h", $time, ascii_char);
      end else begin
        want = char_queue.pop_front();
        chars_checked++;
        if (ascii_char !== want) begin
          errors++;
          $display("%0t: ascii_char mismatch: expected %h, actual %h",
                   $time, want, ascii_char);
        end
      end
    end
  end

  always @(posedge clk)
    if (!rst && in_valid && in_stall)
      input_held++;

  initial begin
    build_keymaps();
    key_cfg = '{kbd_pkg::CAPS_LOCK_RESET, kbd_pkg::LEFT_SHIFT_RESET,
                kbd_pkg::RIGHT_SHIFT_RESET, kbd_pkg::MOUSE_THR_RESET};
    skip_st = kbd_pkg::SKIP_IDLE;
    mode_st = kbd_pkg::MOD_NONE;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_random_typing(300);
    test_key_corners();
    test_random_configs();
    test_output_hold();
    settle();
    repeat (8) @(posedge clk);
    $display("Ran %0d scancode items under %0d key settings, %0d characters compared.",
             items_sent, key_settings, chars_checked);
    $display("Output hold-offs: %0d, cycles with input held back: %0d.",
             holds_done, input_held);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### keyboard_scancode_to_ascii.f
hdl/kbd_pkg.sv
hdl/kbd_cfg_regs.sv
hdl/kbd_xlate.sv
hdl/keyboard_scancode_to_ascii.sv
verif/tb_top.sv
